// File: src/msk_pkg.sv
package msk_pkg;

	// stack geometry
	localparam int unsigned DEPTH  = 1024;
	localparam int unsigned ADDR_W = $clog2(DEPTH);
	localparam int unsigned CNT_W  = $clog2(DEPTH + 1);

	localparam int unsigned DATA_W  = 32;
	localparam int unsigned ENTRY_W = 2 * DATA_W;

	// tdata of a result word, padded to whole bytes
	localparam int unsigned RES_W   = 2 * DATA_W + 3;
	localparam int unsigned RES_PAD = ((RES_W + 7) / 8) * 8;

	// command codes
	localparam logic [1:0] CMD_PUSH = 2'd0;
	localparam logic [1:0] CMD_POP  = 2'd1;
	localparam logic [1:0] CMD_PEEK = 2'd2;

	// minimum reported by an empty stack
	localparam logic signed [DATA_W-1:0] MIN_EMPTY = 32'sh7FFF_FFFF;

	localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

	typedef logic [ENTRY_W-1:0] entry_t;

endpackage

// File: src/msk_ram.sv
module msk_ram (
	input  logic                       clk,
	input  logic                       wr_en,
	input  logic [msk_pkg::ADDR_W-1:0] wr_addr,
	input  msk_pkg::entry_t            wr_data,
	input  logic                       rd_en,
	input  logic [msk_pkg::ADDR_W-1:0] rd_addr,
	output msk_pkg::entry_t            rd_data
);

	msk_pkg::entry_t mem [msk_pkg::DEPTH];
	msk_pkg::entry_t rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

// File: src/min_tracking_stack.sv
// Channel  Dir  tvalid/tready  tuser      tdata
// s_*      in   yes            cmd[1:0]   value[31:0]
// m_*      out  yes            -          top_value, min_value, is_empty, is_full, op_error
//
// Push, peek, a failed command, and a pop that empties the stack are answered without a
// memory read. A pop that leaves entries goes through the fetch state: the new top comes
// from the entry memory, whose read port is registered.
// Reset (arst_n low) empties the stack at once; the entry memory is not cleared.
// A result word waits in the output register; a new command is taken in the
// same cycle the waiting word is taken.
module min_tracking_stack (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         s_tvalid,
	output logic                         s_tready,
	input  logic [1:0]                   s_tuser,  // [1:0] cmd
	input  logic [31:0]                  s_tdata,  // [31:0] value
	output logic                         m_tvalid,
	input  logic                         m_tready,
	// [31:0] top_value, [63:32] min_value, [64] is_empty, [65] is_full,
	// [66] op_error, rest zero
	output logic [msk_pkg::RES_PAD-1:0]  m_tdata
);

	localparam logic ST_IDLE = 1'b0;
	localparam logic ST_LOAD = 1'b1;

	logic                          state_q;
	logic [msk_pkg::CNT_W-1:0]     count_q;
	logic signed [31:0]            top_q;    // cached top entry
	logic signed [31:0]            tmin_q;   // minimum stored with it

	logic                          m_tvalid_q;
	logic signed [31:0]            out_top_q;
	logic signed [31:0]            out_min_q;
	logic                          out_empty_q;
	logic                          out_full_q;
	logic                          out_err_q;

	logic                          accept;
	logic [1:0]                    cmd;
	logic signed [31:0]            value;
	logic                          push_ok;
	logic                          pop_ok;
	logic                          need_load;
	logic                          cmd_err;
	logic [msk_pkg::CNT_W-1:0]     cnt_nx;
	logic signed [31:0]            top_nx;
	logic signed [31:0]            min_nx;
	logic signed [31:0]            push_min;

	logic                          wr_en;
	logic [msk_pkg::ADDR_W-1:0]    wr_addr;
	msk_pkg::entry_t               wr_data;
	logic                          rd_en;
	logic [msk_pkg::ADDR_W-1:0]    rd_addr;
	msk_pkg::entry_t               rd_data;
	logic [msk_pkg::CNT_W-1:0]     cnt_less2;

	assign cmd   = s_tuser;
	assign value = $signed(s_tdata);

	// take a word only when idle and the output slot is free or freeing
	assign s_tready = (state_q == ST_IDLE) && (!m_tvalid_q || m_tready);
	assign accept   = s_tvalid && s_tready;

	assign push_ok   = (cmd == msk_pkg::CMD_PUSH) && (count_q != msk_pkg::CNT_FULL);
	assign pop_ok    = (cmd == msk_pkg::CMD_POP) && (count_q != '0);
	assign cmd_err   = ((cmd == msk_pkg::CMD_PUSH) && (count_q == msk_pkg::CNT_FULL)) ||
		((cmd == msk_pkg::CMD_POP) && (count_q == '0));
	// a pop that leaves entries has to fetch the new top
	assign need_load = pop_ok && (count_q != msk_pkg::CNT_W'(1));

	assign push_min  = (value < tmin_q) ? value : tmin_q;
	assign cnt_less2 = count_q - msk_pkg::CNT_W'(2);

	always_comb begin
		cnt_nx = count_q;
		top_nx = top_q;
		min_nx = tmin_q;
		if (push_ok) begin
			cnt_nx = count_q + msk_pkg::CNT_W'(1);
			top_nx = value;
			min_nx = push_min;
		end else if (pop_ok) begin
			cnt_nx = count_q - msk_pkg::CNT_W'(1);
			if (!need_load) begin
				top_nx = '0;
				min_nx = msk_pkg::MIN_EMPTY;
			end
		end
	end

	// every entry lives in memory; the top is also cached in registers
	assign wr_en   = accept && push_ok;
	assign wr_addr = count_q[msk_pkg::ADDR_W-1:0];
	assign wr_data = {push_min, value};
	assign rd_en   = accept && need_load;
	assign rd_addr = cnt_less2[msk_pkg::ADDR_W-1:0];

	msk_ram u_ram (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			count_q    <= '0;
			top_q      <= '0;
			tmin_q     <= msk_pkg::MIN_EMPTY;
			m_tvalid_q <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						count_q <= cnt_nx;
						top_q   <= top_nx;
						tmin_q  <= min_nx;
						if (need_load) begin
							state_q    <= ST_LOAD;
							m_tvalid_q <= 1'b0;
						end else begin
							m_tvalid_q <= 1'b1;
						end
					end else if (m_tready) begin
						m_tvalid_q <= 1'b0;
					end
				end
				ST_LOAD: begin
					// fetched entry becomes the top; the output slot is free
					top_q      <= $signed(rd_data[31:0]);
					tmin_q     <= $signed(rd_data[63:32]);
					m_tvalid_q <= 1'b1;
					state_q    <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// result payload, no reset needed
	always_ff @(posedge clk) begin
		if (state_q == ST_LOAD) begin
			out_top_q   <= $signed(rd_data[31:0]);
			out_min_q   <= $signed(rd_data[63:32]);
			out_empty_q <= 1'b0;
			out_full_q  <= 1'b0;
			out_err_q   <= 1'b0;
		end else if (accept) begin
			out_top_q   <= top_nx;
			out_min_q   <= min_nx;
			out_empty_q <= (cnt_nx == '0);
			out_full_q  <= (cnt_nx == msk_pkg::CNT_FULL);
			out_err_q   <= cmd_err;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {{(msk_pkg::RES_PAD - msk_pkg::RES_W){1'b0}},
		out_err_q, out_full_q, out_empty_q, out_min_q, out_top_q};

	// the fetch state follows only a pop that leaves entries
	a_load_after_pop: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_LOAD) |-> $past(accept && need_load))
		else $error("fetch state without a preceding pop");

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= msk_pkg::CNT_FULL)
		else $error("entry count beyond depth");

	// an empty result always carries the empty top and minimum
	a_empty_result: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid_q && out_empty_q) |->
		(out_top_q == '0) && (out_min_q == msk_pkg::MIN_EMPTY))
		else $error("empty result with stale top or minimum");

	// cached minimum never exceeds the cached top while entries remain
	a_min_le_top: assert property (@(posedge clk) disable iff (!arst_n)
		((state_q == ST_IDLE) && (count_q != '0)) |-> (tmin_q <= top_q))
		else $error("cached minimum above cached top");

endmodule

// File: bench/tb_top.sv
`timescale 1ns / 100ps

module tb_top;

	// command code the block does not define; it must behave as a peek
	localparam logic [1:0] CMD_UNUSED = 2'd3;

	localparam int unsigned MAX_PRINTED = 30;

	// fields of one command word, plus the idle profile and drain hold it runs under
	typedef struct {
		logic [1:0]  cmd;
		logic [31:0] value;
		int          phase;
		bit          drain_first;
	} stack_cmd_t;

	// result word as packed on m_tdata, lowest field last
	typedef struct packed {
		logic        op_error;
		logic        is_full;
		logic        is_empty;
		logic [31:0] min_value;
		logic [31:0] top_value;
	} stack_view_t;

	logic                        clk      = 1'b0;
	logic                        arst_n   = 1'b0;
	logic                        s_tvalid = 1'b0;
	logic                        s_tready;
	logic [1:0]                  s_tuser  = msk_pkg::CMD_PEEK;
	logic [31:0]                 s_tdata  = '0;
	logic                        m_tvalid;
	logic                        m_tready = 1'b0;
	logic [msk_pkg::RES_PAD-1:0] m_tdata;

	stack_cmd_t   pending_cmds[$];
	stack_view_t  expected_views[$];

	// shadow stack: value and running minimum per entry, plus the depth
	logic [31:0]  shadow_values[msk_pkg::DEPTH];
	logic [31:0]  shadow_mins[msk_pkg::DEPTH];
	int unsigned  shadow_depth = 0;

	// depth the command plan reaches, used only to shape the stimulus
	int unsigned  planned_depth = 0;

	int unsigned  words_sent   = 0;
	int unsigned  results_seen = 0;
	int unsigned  mismatches   = 0;
	int           idle_phase   = 0;

	min_tracking_stack dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tuser  (s_tuser),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	always #5 clk = ~clk;

	// Apply one command to the shadow stack and return what the block must report.
	function automatic stack_view_t apply_to_shadow(logic [1:0] cmd, logic [31:0] value);
		stack_view_t view;
		logic [31:0] below;
		view.op_error = 1'b0;
		case (cmd)
			msk_pkg::CMD_PUSH: begin
				if (shadow_depth >= msk_pkg::DEPTH) begin
					view.op_error = 1'b1;
				end else begin
					below = (shadow_depth == 0) ? msk_pkg::MIN_EMPTY
						: shadow_mins[shadow_depth - 1];
					shadow_values[shadow_depth] = value;
					// an equal value keeps the minimum below it; same bits either way
					shadow_mins[shadow_depth] = ($signed(value) < $signed(below)) ? value : below;
					shadow_depth++;
				end
			end
			msk_pkg::CMD_POP: begin
				if (shadow_depth == 0)
					view.op_error = 1'b1;
				else
					shadow_depth--;
			end
			default: ; // peek and the unused code leave the stack alone
		endcase
		if (shadow_depth == 0) begin
			view.top_value = '0;
			view.min_value = msk_pkg::MIN_EMPTY;
		end else begin
			view.top_value = shadow_values[shadow_depth - 1];
			view.min_value = shadow_mins[shadow_depth - 1];
		end
		view.is_empty = (shadow_depth == 0);
		view.is_full  = (shadow_depth >= msk_pkg::DEPTH);
		return view;
	endfunction

	task automatic report_mismatch(input string field, input logic [31:0] got,
			input logic [31:0] want);
		if (mismatches < MAX_PRINTED)
			$display("%0t: result %0d: %s is %h, expected %h", $time, results_seen,
				field, got, want);
		mismatches++;
	endtask

	// Driver: hold a word until it is taken, then predict it and fetch the next one.
	always @(posedge clk) begin
		int unsigned sent_now;
		int          send_idle_pct;
		bit          taken;
		if (arst_n) begin
			taken = s_tvalid && s_tready;
			sent_now = words_sent;
			if (taken) begin
				expected_views.push_back(apply_to_shadow(s_tuser, s_tdata));
				sent_now = words_sent + 1;
				words_sent <= sent_now;
			end
			if (!s_tvalid || taken) begin
				send_idle_pct = (idle_phase == 0) ? 34 : (idle_phase == 1) ? 62 : 0;
				if (pending_cmds.size() > 0 && pending_cmds[0].phase != idle_phase)
					send_idle_pct = 0;
				if (pending_cmds.size() > 0
						&& !(pending_cmds[0].drain_first && sent_now != results_seen)
						&& $urandom_range(99) >= send_idle_pct) begin
					s_tvalid   <= 1'b1;
					s_tuser    <= pending_cmds[0].cmd;
					s_tdata    <= pending_cmds[0].value;
					idle_phase <= pending_cmds[0].phase;
					void'(pending_cmds.pop_front());
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// Monitor: check each taken result word against the oldest prediction.
	always @(posedge clk) begin
		stack_view_t got;
		stack_view_t want;
		int          recv_idle_pct;
		if (arst_n) begin
			if (m_tvalid && m_tready) begin
				got = stack_view_t'(m_tdata[$bits(stack_view_t)-1:0]);
				if (expected_views.size() == 0) begin
					report_mismatch("unexpected word", got.top_value, '0);
				end else begin
					want = expected_views.pop_front();
					if (got.top_value !== want.top_value)
						report_mismatch("top_value", got.top_value, want.top_value);
					if (got.min_value !== want.min_value)
						report_mismatch("min_value", got.min_value, want.min_value);
					if (got.is_empty !== want.is_empty)
						report_mismatch("is_empty", 32'(got.is_empty), 32'(want.is_empty));
					if (got.is_full !== want.is_full)
						report_mismatch("is_full", 32'(got.is_full), 32'(want.is_full));
					if (got.op_error !== want.op_error)
						report_mismatch("op_error", 32'(got.op_error), 32'(want.op_error));
				end
				if (m_tdata[msk_pkg::RES_PAD-1:$bits(stack_view_t)] !== '0)
					report_mismatch("padding",
						32'(m_tdata[msk_pkg::RES_PAD-1:$bits(stack_view_t)]), '0);
				results_seen <= results_seen + 1;
			end
			recv_idle_pct = (idle_phase == 0) ? 62 : (idle_phase == 1) ? 34 : 0;
			m_tready <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	// Favor extremes and a narrow band of small values so equal values show up.
	function automatic logic [31:0] pick_value();
		case ($urandom_range(7))
			0:       return 32'h8000_0000;
			1:       return msk_pkg::MIN_EMPTY;
			2:       return $urandom_range(1) ? 32'h0 : 32'hFFFF_FFFF;
			3, 4:    return 32'($signed($urandom_range(15)) - 8);
			default: return $urandom;
		endcase
	endfunction

	task automatic plan_cmd(input logic [1:0] cmd, input logic [31:0] value,
			input int phase, input bit drain_first = 1'b0);
		stack_cmd_t item;
		item.cmd         = cmd;
		item.value       = value;
		item.phase       = phase;
		item.drain_first = drain_first;
		pending_cmds.push_back(item);
		if (cmd == msk_pkg::CMD_PUSH && planned_depth < msk_pkg::DEPTH)
			planned_depth++;
		else if (cmd == msk_pkg::CMD_POP && planned_depth > 0)
			planned_depth--;
	endtask

	// Random mix of commands; pop and peek carry random data too.
	task automatic plan_random_walk(input int count, input int phase, input int push_pct);
		int pick;
		repeat (count) begin
			pick = $urandom_range(99);
			if (pick < push_pct)
				plan_cmd(msk_pkg::CMD_PUSH, pick_value(), phase);
			else begin
				pick = $urandom_range(99);
				if (pick < 60)
					plan_cmd(msk_pkg::CMD_POP, $urandom, phase);
				else if (pick < 95)
					plan_cmd(msk_pkg::CMD_PEEK, $urandom, phase);
				else
					plan_cmd(CMD_UNUSED, $urandom, phase);
			end
		end
	endtask

	initial begin
		// directed: empty-stack errors, extremes, equal minimum, unused code
		plan_cmd(msk_pkg::CMD_POP, 32'hFFFF_FFFF, 0);
		plan_cmd(msk_pkg::CMD_PEEK, 32'h1234_5678, 0);
		plan_cmd(CMD_UNUSED, 32'hFFFF_FFFF, 0);
		plan_cmd(msk_pkg::CMD_PUSH, msk_pkg::MIN_EMPTY, 0);
		plan_cmd(msk_pkg::CMD_PUSH, 32'h0, 0);
		plan_cmd(msk_pkg::CMD_PUSH, msk_pkg::MIN_EMPTY, 0);
		plan_cmd(msk_pkg::CMD_PUSH, 32'h8000_0000, 0);
		plan_cmd(msk_pkg::CMD_PUSH, 32'h8000_0000, 0);
		plan_cmd(msk_pkg::CMD_PUSH, 32'hFFFF_FFFF, 0);
		plan_cmd(msk_pkg::CMD_PEEK, 32'h0, 0);
		plan_cmd(CMD_UNUSED, 32'h0, 0);
		plan_cmd(msk_pkg::CMD_POP, 32'h8000_0000, 0);
		plan_cmd(msk_pkg::CMD_POP, 32'h0, 0);
		plan_cmd(msk_pkg::CMD_POP, 32'h0, 0);
		plan_cmd(msk_pkg::CMD_PUSH, 32'h0000_0001, 0);
		plan_cmd(msk_pkg::CMD_POP, 32'h0, 0);
		plan_cmd(msk_pkg::CMD_POP, 32'h0, 0);
		plan_cmd(msk_pkg::CMD_POP, 32'h0, 0);
		plan_cmd(msk_pkg::CMD_POP, 32'h0, 0);
		plan_cmd(msk_pkg::CMD_POP, msk_pkg::MIN_EMPTY, 0);
		plan_random_walk(150, 0, 55);

		// fill to the top, hammer the full stack, then wander near it
		plan_cmd(msk_pkg::CMD_PEEK, $urandom, 1, 1'b1);
		while (planned_depth < msk_pkg::DEPTH) begin
			if ($urandom_range(19) == 0)
				plan_cmd(msk_pkg::CMD_PEEK, $urandom, 1);
			else
				plan_cmd(msk_pkg::CMD_PUSH, pick_value(), 1);
		end
		repeat (4) plan_cmd(msk_pkg::CMD_PUSH, pick_value(), 1);
		plan_cmd(msk_pkg::CMD_POP, $urandom, 1);
		plan_cmd(msk_pkg::CMD_PUSH, pick_value(), 1);
		plan_cmd(msk_pkg::CMD_PUSH, pick_value(), 1);
		plan_cmd(CMD_UNUSED, $urandom, 1);
		plan_random_walk(40, 1, 50);

		// no idling on either side; drift down from the top
		plan_cmd(msk_pkg::CMD_PEEK, $urandom, 2, 1'b1);
		plan_random_walk(100, 2, 35);

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		// sample on the falling edge so the driver's updates have settled
		while (pending_cmds.size() > 0 || s_tvalid) @(negedge clk);
		while (results_seen != words_sent) @(negedge clk);
		repeat (8) @(posedge clk);
		if (expected_views.size() != 0)
			report_mismatch("results missing", 32'(expected_views.size()), '0);

		if (mismatches == 0)
			$display("[min_tracking_stack] OK");
		else
			$display("[min_tracking_stack] ERROR");
		$finish;
	end

	initial begin
		#5_000_000;
		$display("[min_tracking_stack] ERROR");
		$finish;
	end

endmodule
